FILE: src/twhl_pkg.sv
// Shared types and constants for the two-wire handshake link.
// Holds the item structs, the front-to-back record, state and code names.
// No dependencies.
package twhl_pkg;

	localparam int TO_W    = 24;   // timeout register width
	localparam int DLY_W   = 16;   // bit delay register width
	localparam int CFG_IW  = 2;    // config index width
	localparam int CFG_DW  = 24;   // config data width

	localparam logic [CFG_IW-1:0] CFG_TIMEOUT   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_BIT_DELAY = 2'd1;

	localparam logic [TO_W-1:0]  TIMEOUT_RST = 24'd1000000;
	localparam logic [DLY_W-1:0] DELAY_RST   = 16'd0;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SEND = 2'd1;
	localparam logic [1:0] OP_RECV = 2'd2;
	localparam logic [1:0] OP_REL  = 2'd3;

	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_SEND_TO = 2'd1;
	localparam logic [1:0] RES_RECV_TO = 2'd2;

	// Line drive, bit 0 is A, bit 1 is B, 1 means released.
	localparam logic [1:0] DRV_REL    = 2'b11;
	localparam logic [1:0] DRV_PULL_A = 2'b10;
	localparam logic [1:0] DRV_PULL_B = 2'b01;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_SEND,
		CMD_RECV,
		CMD_REL
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_TX_PULL,
		PH_TX_RELW,
		PH_RX_WAIT,
		PH_RX_ACK,
		PH_SETTLE_TX,
		PH_SETTLE_RX,
		PH_REL
	} phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] tx_byte;
		logic       line_a_in;
		logic       line_b_in;
	} in_t;

	typedef struct packed {
		logic       release_a;
		logic       release_b;
		logic       busy_res;
		logic [7:0] rx_byte;
		logic       byte_done;
		logic [1:0] result_code;
		logic       line_activity;
	} out_t;

	// Classified item handed from the front to the engine.
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       line_a;
		logic       line_b;
		logic       both_high;
		logic       rx_one;     // A high, B low
	} cls_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

FILE: src/two_wire_handshake_link.sv
// An accepted item is registered in the queue; its result is registered when the engine pops it.
// Throughput: one item per cycle unless the output stalls; the engine steps once per queued item.
// A two-entry queue decouples input from the engine; the result register decouples output.
// Reset (arst_n low): lines released, engine idle, timeout 1000000, bit delay 0.
// Config writes are always ready and take effect on the next cycle.
module two_wire_handshake_link #(
	parameter int TIMER_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  twhl_pkg::in_t               in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output twhl_pkg::out_t              out_item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [twhl_pkg::CFG_IW-1:0] cfg_index,
	input  logic [twhl_pkg::CFG_DW-1:0] cfg_data
);

	twhl_pkg::cls_t   cls;
	twhl_pkg::cls_t   head;
	twhl_pkg::qstat_t qstat;
	logic             push;
	logic             pop;

	assign cfg_ready = 1'b1;

	twhl_front u_front (
		.in_valid (in_valid),
		.in_item  (in_item),
		.qstat    (qstat),
		.in_stall (in_stall),
		.push     (push),
		.cls      (cls)
	);

	twhl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	twhl_engine #(
		.TIMER_BITS (TIMER_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

FILE: src/twhl_front.sv
// Front end: takes input items and classifies them for the engine.
// Decodes the command and precomputes line conditions. Uses twhl_pkg.
module twhl_front (
	input  logic            in_valid,
	input  twhl_pkg::in_t   in_item,
	input  twhl_pkg::qstat_t qstat,
	output logic            in_stall,
	output logic            push,
	output twhl_pkg::cls_t  cls
);

	always_comb begin
		cls.tx_byte   = in_item.tx_byte;
		cls.line_a    = in_item.line_a_in;
		cls.line_b    = in_item.line_b_in;
		cls.both_high = in_item.line_a_in & in_item.line_b_in;
		cls.rx_one    = in_item.line_a_in & ~in_item.line_b_in;
		unique case (in_item.op)
			twhl_pkg::OP_SEND: cls.cmd = twhl_pkg::CMD_SEND;
			twhl_pkg::OP_RECV: cls.cmd = twhl_pkg::CMD_RECV;
			twhl_pkg::OP_REL:  cls.cmd = twhl_pkg::CMD_REL;
			default:           cls.cmd = twhl_pkg::CMD_TICK;
		endcase
	end

	assign in_stall = qstat.full;
	assign push     = in_valid & ~qstat.full;

endmodule

FILE: src/twhl_queue.sv
// Two-entry queue between the front end and the engine.
// Holds classified items so each side can stall on its own. Uses twhl_pkg.
module twhl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  twhl_pkg::cls_t   push_data,
	input  logic             pop,
	output twhl_pkg::cls_t   head,
	output twhl_pkg::qstat_t qstat
);

	twhl_pkg::cls_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = cnt_q[1];
	assign qstat.empty = (cnt_q == 2'd0);

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");

endmodule

FILE: src/twhl_engine.sv
// Back end: handshake state machine, config registers and result register.
// Steps one classified item per cycle while the queue holds one and the output is not stalled. Uses twhl_pkg.
module twhl_engine #(
	parameter int TIMER_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [twhl_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [twhl_pkg::CFG_DW-1:0]   cfg_data,
	input  twhl_pkg::cls_t                head,
	input  twhl_pkg::qstat_t              qstat,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output twhl_pkg::out_t                out_item
);

	localparam int CMP_W = (TIMER_BITS > twhl_pkg::TO_W) ? TIMER_BITS : twhl_pkg::TO_W;

	logic [twhl_pkg::TO_W-1:0]  timeout_q;
	logic [twhl_pkg::DLY_W-1:0] delay_q;

	twhl_pkg::phase_t           phase_q, phase_d;
	logic [7:0]                 shift_q, shift_d;
	logic [3:0]                 cnt_q, cnt_d;
	logic [TIMER_BITS-1:0]      timer_q, timer_d;
	logic [twhl_pkg::DLY_W-1:0] settle_q, settle_d;
	logic [1:0]                 drive_q, drive_d;

	logic                       out_valid_q;
	twhl_pkg::out_t             out_q, res;

	logic                  done;
	logic [1:0]            code;
	logic [7:0]            rx;
	logic [TIMER_BITS-1:0] timer_inc;
	logic                  expired;
	logic                  lvl_tx, lvl_ack;
	logic                  end_bit, fin_bit, fin_rx;
	logic [3:0]            cnt_inc;
	logic [7:0]            shift_fb;

	assign pop = ~qstat.empty & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= twhl_pkg::TIMEOUT_RST;
			delay_q   <= twhl_pkg::DELAY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				twhl_pkg::CFG_TIMEOUT:   timeout_q <= cfg_data;
				twhl_pkg::CFG_BIT_DELAY: delay_q   <= cfg_data[twhl_pkg::DLY_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturating wait timer and its expiry test.
	assign timer_inc = (&timer_q) ? timer_q : timer_q + TIMER_BITS'(1);
	assign expired   = CMP_W'(timer_inc) >= CMP_W'(timeout_q);
	assign lvl_tx    = shift_q[0] ? head.line_a : head.line_b;
	assign lvl_ack   = shift_q[7] ? head.line_b : head.line_a;

	// Next state
	always_comb begin
		phase_d  = phase_q;
		shift_d  = shift_q;
		cnt_d    = cnt_q;
		timer_d  = timer_q;
		settle_d = settle_q;
		drive_d  = drive_q;
		done     = 1'b0;
		code     = twhl_pkg::RES_OK;
		rx       = 8'd0;
		end_bit  = 1'b0;
		fin_bit  = 1'b0;
		fin_rx   = 1'b0;
		cnt_inc  = cnt_q + 4'd1;
		shift_fb = shift_q;

		unique case (phase_q)
			twhl_pkg::PH_IDLE: begin
				unique case (head.cmd)
					twhl_pkg::CMD_SEND: begin
						shift_d = head.tx_byte;
						cnt_d   = 4'd0;
						drive_d = head.tx_byte[0] ? twhl_pkg::DRV_PULL_B
							: twhl_pkg::DRV_PULL_A;
						phase_d = twhl_pkg::PH_TX_PULL;
						timer_d = '0;
					end
					twhl_pkg::CMD_RECV: begin
						shift_d = 8'd0;
						cnt_d   = 4'd0;
						drive_d = twhl_pkg::DRV_REL;
						phase_d = twhl_pkg::PH_RX_WAIT;
						timer_d = '0;
					end
					twhl_pkg::CMD_REL: begin
						drive_d = twhl_pkg::DRV_REL;
						phase_d = twhl_pkg::PH_REL;
						timer_d = '0;
					end
					default: ;
				endcase
			end
			twhl_pkg::PH_TX_PULL: begin
				if (!lvl_tx) begin
					drive_d = twhl_pkg::DRV_REL;
					phase_d = twhl_pkg::PH_TX_RELW;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
					if (expired) begin
						done    = 1'b1;
						code    = twhl_pkg::RES_SEND_TO;
						phase_d = twhl_pkg::PH_IDLE;
					end
				end
			end
			twhl_pkg::PH_TX_RELW: begin
				if (lvl_tx) begin
					end_bit = 1'b1;
				end else begin
					timer_d = timer_inc;
					if (expired) begin
						done    = 1'b1;
						code    = twhl_pkg::RES_SEND_TO;
						phase_d = twhl_pkg::PH_IDLE;
					end
				end
			end
			twhl_pkg::PH_RX_WAIT: begin
				if (!head.both_high) begin
					shift_d = {head.rx_one, shift_q[7:1]};
					drive_d = head.rx_one ? twhl_pkg::DRV_PULL_A : twhl_pkg::DRV_PULL_B;
					phase_d = twhl_pkg::PH_RX_ACK;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
					if (expired) begin
						done    = 1'b1;
						code    = twhl_pkg::RES_RECV_TO;
						phase_d = twhl_pkg::PH_IDLE;
					end
				end
			end
			twhl_pkg::PH_RX_ACK: begin
				if (lvl_ack) begin
					end_bit = 1'b1;
					fin_rx  = 1'b1;
				end else begin
					timer_d = timer_inc;
					if (expired) begin
						done    = 1'b1;
						code    = twhl_pkg::RES_RECV_TO;
						phase_d = twhl_pkg::PH_IDLE;
					end
				end
			end
			twhl_pkg::PH_SETTLE_TX, twhl_pkg::PH_SETTLE_RX: begin
				if (settle_q <= twhl_pkg::DLY_W'(1)) begin
					settle_d = '0;
					fin_bit  = 1'b1;
					fin_rx   = (phase_q == twhl_pkg::PH_SETTLE_RX);
				end else begin
					settle_d = settle_q - twhl_pkg::DLY_W'(1);
				end
			end
			twhl_pkg::PH_REL: begin
				if (head.both_high) begin
					done    = 1'b1;
					phase_d = twhl_pkg::PH_IDLE;
				end else begin
					timer_d = timer_inc;
					if (expired) begin
						done    = 1'b1;
						phase_d = twhl_pkg::PH_IDLE;
					end
				end
			end
			default: phase_d = twhl_pkg::PH_IDLE;
		endcase

		// End of a bit: release, then settle or move on at once.
		if (end_bit) begin
			drive_d = twhl_pkg::DRV_REL;
			if (delay_q == '0) begin
				fin_bit = 1'b1;
			end else begin
				settle_d = delay_q;
				phase_d  = fin_rx ? twhl_pkg::PH_SETTLE_RX : twhl_pkg::PH_SETTLE_TX;
			end
		end

		if (fin_bit) begin
			cnt_d = cnt_inc;
			if (!fin_rx) begin
				shift_fb = {1'b0, shift_q[7:1]};
				shift_d  = shift_fb;
			end
			if (cnt_inc[3]) begin
				rx      = fin_rx ? shift_q : 8'd0;
				done    = 1'b1;
				code    = twhl_pkg::RES_OK;
				phase_d = twhl_pkg::PH_IDLE;
			end else if (fin_rx) begin
				phase_d = twhl_pkg::PH_RX_WAIT;
				timer_d = '0;
			end else begin
				drive_d = shift_fb[0] ? twhl_pkg::DRV_PULL_B : twhl_pkg::DRV_PULL_A;
				phase_d = twhl_pkg::PH_TX_PULL;
				timer_d = '0;
			end
		end
	end

	// Result fields
	always_comb begin
		res.release_a     = drive_d[0];
		res.release_b     = drive_d[1];
		res.busy_res      = (phase_d != twhl_pkg::PH_IDLE);
		res.rx_byte       = rx;
		res.byte_done     = done;
		res.result_code   = code;
		res.line_activity = ~head.both_high;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= twhl_pkg::PH_IDLE;
			shift_q     <= 8'd0;
			cnt_q       <= 4'd0;
			timer_q     <= '0;
			settle_q    <= '0;
			drive_q     <= twhl_pkg::DRV_REL;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q  <= phase_d;
				shift_q  <= shift_d;
				cnt_q    <= cnt_d;
				timer_q  <= timer_d;
				settle_q <= settle_d;
				drive_q  <= drive_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_code_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.byte_done) |-> out_q.result_code == twhl_pkg::RES_OK)
		else $error("result code without completion");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.byte_done) |-> (!out_q.busy_res && phase_q == twhl_pkg::PH_IDLE))
		else $error("completion while still busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'd8)
		else $error("bit count out of range");

	a_settle_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == twhl_pkg::PH_SETTLE_TX || phase_q == twhl_pkg::PH_SETTLE_RX)
		|-> settle_q != '0)
		else $error("settle phase with empty counter");

endmodule
